[rtl/rgbh_pkg.sv]
// Shared types and constants for the RGB channel histogram.
// Depends on nothing; rgbh_front, rgbh_back and rgb_channel_histogram import it.
`timescale 1ns / 1ps

package rgbh_pkg;

    // Histogram geometry
    localparam int BIN_COUNT   = 256;
    localparam int COUNT_WIDTH = 21;
    localparam int ADDR_W      = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Fixed field widths of the ports
    localparam int VALUE_W  = 8;
    localparam int ACTION_W = 2;
    localparam int FIELD_W  = 21;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Action codes on the input port
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PIXEL = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PIXEL = 2'd1,
        OP_READ  = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [VALUE_W-1:0] red;
        logic [VALUE_W-1:0] green;
        logic [VALUE_W-1:0] blue;
        logic [VALUE_W-1:0] bin;
    } op_t;

endpackage

[rtl/rgbh_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module rgbh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/rgbh_front.sv]
// Front end: accepts input beats, classifies the action and queues commands.
// Depends on rgbh_pkg.
`timescale 1ns / 1ps

module rgbh_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rgbh_pkg::ACTION_W-1:0]   action,
    input  logic [rgbh_pkg::VALUE_W-1:0]    red_value,
    input  logic [rgbh_pkg::VALUE_W-1:0]    green_value,
    input  logic [rgbh_pkg::VALUE_W-1:0]    blue_value,
    input  logic [rgbh_pkg::VALUE_W-1:0]    bin_index,
    output logic                            q_valid,
    output rgbh_pkg::op_t                   q_item,
    input  logic                            q_pop
);
    import rgbh_pkg::*;

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              accept;
    logic              push;
    op_t               new_op;

    assign in_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign accept   = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        new_op.red   = red_value;
        new_op.green = green_value;
        new_op.blue  = blue_value;
        new_op.bin   = bin_index;
        new_op.kind  = OP_CLEAR;
        push         = accept;
        case (action)
            ACT_CLEAR: new_op.kind = OP_CLEAR;
            ACT_PIXEL: new_op.kind = OP_PIXEL;
            ACT_READ:  new_op.kind = OP_READ;
            // drop the unused code: accepted, never queued
            default:   push = 1'b0;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_op;
        end
    end

endmodule

[rtl/rgbh_back.sv]
// Back end: runs queued commands against the three bin memories, walks the bins to
// zero them on clear and after reset, and holds the result register.
// Depends on rgbh_pkg, rgbh_ram.
`timescale 1ns / 1ps

module rgbh_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  rgbh_pkg::op_t                   q_item,
    output logic                            q_pop,
    input  logic [rgbh_pkg::VALUE_W-1:0]    chan_limit,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rgbh_pkg::VALUE_W-1:0]    read_bin,
    output logic [rgbh_pkg::FIELD_W-1:0]    red_count,
    output logic [rgbh_pkg::FIELD_W-1:0]    green_count,
    output logic [rgbh_pkg::FIELD_W-1:0]    blue_count,
    output logic                            above_maximum
);
    import rgbh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_CLEAR = 3'b100
    } state_t;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        sat_inc = (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic in_range(input logic [VALUE_W-1:0] v);
        in_range = (32'(v) < BIN_COUNT);
    endfunction

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      clr_addr_reg, clr_addr_next;
    op_t                    op_reg;
    logic                   out_valid_reg;
    logic [VALUE_W-1:0]     read_bin_reg;
    logic [COUNT_WIDTH-1:0] red_out_reg, green_out_reg, blue_out_reg;
    logic                   above_reg;

    logic                   issue;
    logic                   clearing;
    logic                   do_pixel;
    logic                   do_read;
    logic [ADDR_W-1:0]      red_raddr, green_raddr, blue_raddr;
    logic [ADDR_W-1:0]      red_waddr, green_waddr, blue_waddr;
    logic [COUNT_WIDTH-1:0] red_rdata, green_rdata, blue_rdata;
    logic [COUNT_WIDTH-1:0] red_wdata, green_wdata, blue_wdata;
    logic                   red_we, green_we, blue_we;
    logic                   red_ok, green_ok, blue_ok;

    // Issue a command only from idle; a read also needs the result register free.
    // A clear walks every bin, one address per cycle, before returning to idle.
    always_comb
    begin
        issue         = 1'b0;
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && (q_item.kind != OP_READ || !out_valid_reg))
                begin
                    issue = 1'b1;
                    if (q_item.kind == OP_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: state_next = ST_IDLE;
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(BIN_COUNT - 1))
                begin
                    clr_addr_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign q_pop    = issue;
    assign clearing = (state_reg == ST_CLEAR);
    assign do_pixel = (state_reg == ST_EXEC) && (op_reg.kind == OP_PIXEL);
    assign do_read  = (state_reg == ST_EXEC) && (op_reg.kind == OP_READ);

    // A read walks all three memories at the bin; a pixel at its channel values
    always_comb
    begin
        if (q_item.kind == OP_READ)
        begin
            red_raddr   = ADDR_W'(q_item.bin);
            green_raddr = ADDR_W'(q_item.bin);
            blue_raddr  = ADDR_W'(q_item.bin);
        end
        else
        begin
            red_raddr   = ADDR_W'(q_item.red);
            green_raddr = ADDR_W'(q_item.green);
            blue_raddr  = ADDR_W'(q_item.blue);
        end
    end

    assign red_waddr   = clearing ? clr_addr_reg : ADDR_W'(op_reg.red);
    assign green_waddr = clearing ? clr_addr_reg : ADDR_W'(op_reg.green);
    assign blue_waddr  = clearing ? clr_addr_reg : ADDR_W'(op_reg.blue);

    assign red_wdata   = clearing ? '0 : sat_inc(red_rdata);
    assign green_wdata = clearing ? '0 : sat_inc(green_rdata);
    assign blue_wdata  = clearing ? '0 : sat_inc(blue_rdata);

    assign red_ok   = in_range(op_reg.red);
    assign green_ok = in_range(op_reg.green);
    assign blue_ok  = in_range(op_reg.blue);

    assign red_we   = (do_pixel && red_ok) || clearing;
    assign green_we = (do_pixel && green_ok) || clearing;
    assign blue_we  = (do_pixel && blue_ok) || clearing;

    rgbh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BIN_COUNT)) u_red_ram (
        .clk   (clk),
        .we    (red_we),
        .waddr (red_waddr),
        .wdata (red_wdata),
        .re    (issue),
        .raddr (red_raddr),
        .rdata (red_rdata)
    );

    rgbh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BIN_COUNT)) u_green_ram (
        .clk   (clk),
        .we    (green_we),
        .waddr (green_waddr),
        .wdata (green_wdata),
        .re    (issue),
        .raddr (green_raddr),
        .rdata (green_rdata)
    );

    rgbh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BIN_COUNT)) u_blue_ram (
        .clk   (clk),
        .we    (blue_we),
        .waddr (blue_waddr),
        .wdata (blue_wdata),
        .re    (issue),
        .raddr (blue_raddr),
        .rdata (blue_rdata)
    );

    // Start with a clearing pass so that every bin holds zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            if (do_read)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            op_reg <= q_item;
        end
        if (do_read)
        begin
            read_bin_reg <= op_reg.bin;
            above_reg    <= (op_reg.bin > chan_limit);
            if (in_range(op_reg.bin))
            begin
                red_out_reg   <= red_rdata;
                green_out_reg <= green_rdata;
                blue_out_reg  <= blue_rdata;
            end
            else
            begin
                red_out_reg   <= '0;
                green_out_reg <= '0;
                blue_out_reg  <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_bin      = read_bin_reg;
    assign red_count     = FIELD_W'(red_out_reg);
    assign green_count   = FIELD_W'(green_out_reg);
    assign blue_count    = FIELD_W'(blue_out_reg);
    assign above_maximum = above_reg;

endmodule

[rtl/rgb_channel_histogram.sv]
// RGB channel histogram: three saturating 256-bin histograms behind a command queue.
// Back end: a pixel or read beat is a memory read, then an update or capture; a clear is
// an issue, then one zero write per bin; each command ends before the next one issues.
// A read result is registered in the queue entry, the memory read and the result register;
// it issues once the back end is idle and the result register is free.
// Reset: a clearing pass zeroes the bins, beats queue two deep and then stall until it
// ends; the channel limit resets to 255. Depends on rgbh_pkg, rgbh_front, rgbh_back.
`timescale 1ns / 1ps

module rgb_channel_histogram (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rgbh_pkg::VALUE_W-1:0]    cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rgbh_pkg::ACTION_W-1:0]   action,
    input  logic [rgbh_pkg::VALUE_W-1:0]    red_value,
    input  logic [rgbh_pkg::VALUE_W-1:0]    green_value,
    input  logic [rgbh_pkg::VALUE_W-1:0]    blue_value,
    input  logic [rgbh_pkg::VALUE_W-1:0]    bin_index,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rgbh_pkg::VALUE_W-1:0]    read_bin,
    output logic [rgbh_pkg::FIELD_W-1:0]    red_count,
    output logic [rgbh_pkg::FIELD_W-1:0]    green_count,
    output logic [rgbh_pkg::FIELD_W-1:0]    blue_count,
    output logic                            above_maximum
);
    import rgbh_pkg::*;

    logic [VALUE_W-1:0] chan_limit_reg;
    logic               q_valid;
    op_t                q_item;
    logic               q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_limit_reg <= '1;
        end
        else if (cfg_we)
        begin
            chan_limit_reg <= cfg_wdata;
        end
    end

    rgbh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .red_value   (red_value),
        .green_value (green_value),
        .blue_value  (blue_value),
        .bin_index   (bin_index),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    rgbh_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .chan_limit    (chan_limit_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_bin      (read_bin),
        .red_count     (red_count),
        .green_count   (green_count),
        .blue_count    (blue_count),
        .above_maximum (above_maximum)
    );

endmodule
